// File: rtl/sirt_pkg.sv
// ----------------------------------------------------------------------------
// sirt_pkg
// Shared types, constants, microcode and helpers for the signed integer to
// radix text converter.
// ----------------------------------------------------------------------------
package sirt_pkg;

  localparam int unsigned MAX_RADIX_DEF  = 32;
  localparam int unsigned VALUE_BITS_DEF = 32;

  localparam int unsigned ALPHA_REGS = 4;
  localparam int unsigned CFG_W      = 64;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned RADIX_W    = 6;
  localparam int unsigned DIGIT_W    = 5;
  localparam int unsigned DIV_BITS   = 8;
  localparam int unsigned PC_W       = 4;

  localparam logic [7:0] CHAR_MINUS = 8'd45;
  localparam logic [7:0] CHAR_PLUS  = 8'd43;
  localparam logic [7:0] CHAR_LOW   = 8'd32;
  localparam logic [7:0] CHAR_DEL   = 8'd127;
  localparam logic [7:0] CHAR_NONE  = 8'd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ALPHA_0 = 3'd0,
    CFG_ALPHA_1 = 3'd1,
    CFG_ALPHA_2 = 3'd2,
    CFG_ALPHA_3 = 3'd3,
    CFG_RADIX   = 3'd4
  } cfg_idx_e;

  typedef logic [ALPHA_REGS-1:0][CFG_W-1:0] alpha_t;

  typedef enum logic [2:0] {
    ACT_NOP,
    ACT_LOAD,
    ACT_LEN,
    ACT_CHK,
    ACT_DIV,
    ACT_SIGN,
    ACT_DIGIT,
    ACT_ERR
  } act_e;

  typedef enum logic [3:0] {
    COND_NEXT,
    COND_ALWAYS,
    COND_NO_IN,
    COND_LEN_BAD,
    COND_CHK_MORE,
    COND_BAD,
    COND_DIV_MORE,
    COND_MAG_NZ,
    COND_DIG_MORE
  } cond_e;

  typedef struct packed {
    act_e            act;
    cond_e           cond;
    logic [PC_W-1:0] target;
  } ucode_t;

  typedef struct packed {
    logic num_valid;
    logic len_bad;
    logic chk_more;
    logic bad;
    logic div_more;
    logic mag_nz;
    logic dig_more;
    logic out_stall;
  } seq_stat_t;

  localparam logic [PC_W-1:0] PC_IDLE    = 4'd0;
  localparam logic [PC_W-1:0] PC_LEN     = 4'd1;
  localparam logic [PC_W-1:0] PC_CHK     = 4'd2;
  localparam logic [PC_W-1:0] PC_CHK_END = 4'd3;
  localparam logic [PC_W-1:0] PC_DIV     = 4'd4;
  localparam logic [PC_W-1:0] PC_DIV_END = 4'd5;
  localparam logic [PC_W-1:0] PC_SIGN    = 4'd6;
  localparam logic [PC_W-1:0] PC_DIGIT   = 4'd7;
  localparam logic [PC_W-1:0] PC_DONE    = 4'd8;
  localparam logic [PC_W-1:0] PC_ERR     = 4'd9;

  // Jump taken when cond holds, else fall through to pc + 1.
  function automatic ucode_t ucode_rom(logic [PC_W-1:0] pc);
    ucode_t w;
    unique case (pc)
      PC_IDLE:    w = '{ACT_LOAD,  COND_NO_IN,    PC_IDLE};
      PC_LEN:     w = '{ACT_LEN,   COND_LEN_BAD,  PC_ERR};
      PC_CHK:     w = '{ACT_CHK,   COND_CHK_MORE, PC_CHK};
      PC_CHK_END: w = '{ACT_NOP,   COND_BAD,      PC_ERR};
      PC_DIV:     w = '{ACT_DIV,   COND_DIV_MORE, PC_DIV};
      PC_DIV_END: w = '{ACT_NOP,   COND_MAG_NZ,   PC_DIV};
      PC_SIGN:    w = '{ACT_SIGN,  COND_NEXT,     PC_IDLE};
      PC_DIGIT:   w = '{ACT_DIGIT, COND_DIG_MORE, PC_DIGIT};
      PC_DONE:    w = '{ACT_NOP,   COND_ALWAYS,   PC_IDLE};
      PC_ERR:     w = '{ACT_ERR,   COND_ALWAYS,   PC_IDLE};
      default:    w = '{ACT_NOP,   COND_ALWAYS,   PC_IDLE};
    endcase
    return w;
  endfunction

  function automatic logic [7:0] alpha_char(alpha_t a, logic [DIGIT_W-1:0] k);
    return a[k[DIGIT_W-1:3]][{k[2:0], 3'b000} +: 8];
  endfunction

  function automatic logic char_bad(logic [7:0] c);
    return (c < CHAR_LOW) || (c >= CHAR_DEL) || (c == CHAR_PLUS) || (c == CHAR_MINUS);
  endfunction

endpackage

// File: rtl/sirt_num_if.sv
// ----------------------------------------------------------------------------
// sirt_num_if
// Request channel carrying one signed value to convert.
// ----------------------------------------------------------------------------
interface sirt_num_if
  import sirt_pkg::*;
#(
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) ();

  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS-1:0] number;

  modport source (output valid, output number, input ready);
  modport sink   (input valid, input number, output ready);

endinterface

// File: rtl/sirt_chr_if.sv
// ----------------------------------------------------------------------------
// sirt_chr_if
// Result channel carrying the output characters of a request, one per transfer.
// ----------------------------------------------------------------------------
interface sirt_chr_if ();

  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       final_char;
  logic       alphabet_bad;

  modport source (output valid, output character, output final_char,
                  output alphabet_bad, input ready);
  modport sink   (input valid, input character, input final_char,
                  input alphabet_bad, output ready);

endinterface

// File: rtl/signed_int_to_radix_text.sv
// ----------------------------------------------------------------------------
// signed_int_to_radix_text
// Converts a signed value into characters of a configurable radix alphabet.
// ----------------------------------------------------------------------------
// Sequence: accept, length check, alphabet check over each entry, then one divide pass
//   per digit, then sign, digits and done; a bad alphabet ends in a single error result.
// Throughput: one request at a time, set by the 8-bit-per-cycle divide loop.
// Reset: configuration cleared, sequencer idle, output register empty.
module signed_int_to_radix_text
  import sirt_pkg::*;
#(
  parameter int unsigned MAX_RADIX  = MAX_RADIX_DEF,
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  sirt_num_if.sink             num_i,
  sirt_chr_if.source           chr_o
);

  localparam int unsigned DIV_STEPS = (VALUE_BITS + DIV_BITS - 1) / DIV_BITS;
  localparam int unsigned WB        = DIV_STEPS * DIV_BITS;
  localparam int unsigned DCNT_W    = $clog2(VALUE_BITS + 1);
  localparam int unsigned DIVC_W    = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

  ucode_t    ucode;
  seq_stat_t stat;

  alpha_t               alpha_q;
  logic [RADIX_W-1:0]   radix_q;
  logic [WB-1:0]        mag_q;
  logic [DIGIT_W-1:0]   rem_q;
  logic                 neg_q;
  logic                 bad_q;
  logic [DIGIT_W-1:0]   chk_q;
  logic [DIVC_W-1:0]    div_cnt_q;
  logic [DCNT_W-1:0]    dcnt_q;
  logic [VALUE_BITS-1:0][DIGIT_W-1:0] stk_q;
  logic                 ovalid_q;
  logic [7:0]           ochar_q;
  logic                 ofinal_q;
  logic                 obad_q;

  logic [VALUE_BITS-1:0] num_raw, num_mag;
  logic                  len_bad;
  logic [7:0]            chk_c;
  logic                  chk_dup, chk_bad;
  logic [DIGIT_W:0]      dv_t;
  logic [DIGIT_W-1:0]    dv_r;
  logic [WB-1:0]         dv_w;
  logic                  div_last;
  logic [7:0]            dig_c;
  logic                  need_out, out_free, emit;
  logic                  in_acc, push, pop;

  sirt_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .stat_i  (stat),
    .ucode_o (ucode)
  );

  always_comb begin
    num_raw = num_i.number;
    num_mag = num_raw[VALUE_BITS-1] ? (~num_raw + VALUE_BITS'(1)) : num_raw;
    len_bad = (radix_q < RADIX_W'(2)) || (radix_q > RADIX_W'(MAX_RADIX));
  end

  // One alphabet entry checked for a bad character and against the ones above it.
  always_comb begin
    chk_c   = alpha_char(alpha_q, chk_q);
    chk_dup = 1'b0;
    for (int j = 0; j < MAX_RADIX; j++) begin
      if ((DIGIT_W'(j) > chk_q) && (RADIX_W'(j) < radix_q) &&
          (alpha_char(alpha_q, DIGIT_W'(j)) == chk_c)) begin
        chk_dup = 1'b1;
      end
    end
    chk_bad = char_bad(chk_c) || chk_dup;
  end

  // Restoring divide, DIV_BITS quotient bits per cycle.
  always_comb begin
    dv_r = rem_q;
    dv_w = mag_q;
    dv_t = '0;
    for (int b = 0; b < DIV_BITS; b++) begin
      dv_t = {dv_r, dv_w[WB-1]};
      dv_w = {dv_w[WB-2:0], 1'b0};
      if (dv_t >= radix_q) begin
        dv_t    = dv_t - radix_q;
        dv_w[0] = 1'b1;
      end
      dv_r = dv_t[DIGIT_W-1:0];
    end
  end

  always_comb begin
    dig_c    = alpha_char(alpha_q, stk_q[0]);
    div_last = (div_cnt_q == DIVC_W'(DIV_STEPS - 1));
    need_out = ((ucode.act == ACT_SIGN) && neg_q) || (ucode.act == ACT_DIGIT) ||
               (ucode.act == ACT_ERR);
    out_free = !ovalid_q || chr_o.ready;
    emit     = need_out && out_free;
    in_acc   = (ucode.act == ACT_LOAD) && num_i.valid;
    push     = (ucode.act == ACT_DIV) && div_last;
    pop      = (ucode.act == ACT_DIGIT) && out_free;
  end

  always_comb begin
    stat.num_valid = num_i.valid;
    stat.len_bad   = len_bad;
    stat.chk_more  = (RADIX_W'(chk_q) + RADIX_W'(1)) < radix_q;
    stat.bad       = bad_q;
    stat.div_more  = !div_last;
    stat.mag_nz    = |mag_q;
    stat.dig_more  = (dcnt_q != DCNT_W'(1));
    stat.out_stall = need_out && !out_free;
  end

  assign num_i.ready        = (ucode.act == ACT_LOAD);
  assign chr_o.valid        = ovalid_q;
  assign chr_o.character    = ochar_q;
  assign chr_o.final_char   = ofinal_q;
  assign chr_o.alphabet_bad = obad_q;

  // Configuration and control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q   <= '0;
      radix_q   <= '0;
      neg_q     <= 1'b0;
      bad_q     <= 1'b0;
      chk_q     <= '0;
      div_cnt_q <= '0;
      dcnt_q    <= '0;
      ovalid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_ALPHA_0: alpha_q[0] <= cfg_wdata_i;
          CFG_ALPHA_1: alpha_q[1] <= cfg_wdata_i;
          CFG_ALPHA_2: alpha_q[2] <= cfg_wdata_i;
          CFG_ALPHA_3: alpha_q[3] <= cfg_wdata_i;
          CFG_RADIX:   radix_q    <= cfg_wdata_i[RADIX_W-1:0];
          default: begin
          end
        endcase
      end
      if (in_acc) begin
        neg_q     <= num_raw[VALUE_BITS-1];
        div_cnt_q <= '0;
        dcnt_q    <= '0;
      end
      if (ucode.act == ACT_LEN) begin
        bad_q <= len_bad;
        chk_q <= '0;
      end
      if (ucode.act == ACT_CHK) begin
        bad_q <= bad_q | chk_bad;
        chk_q <= chk_q + DIGIT_W'(1);
      end
      if (ucode.act == ACT_DIV) begin
        div_cnt_q <= div_last ? '0 : div_cnt_q + DIVC_W'(1);
      end
      if (push) begin
        dcnt_q <= dcnt_q + DCNT_W'(1);
      end else if (pop) begin
        dcnt_q <= dcnt_q - DCNT_W'(1);
      end
      if (emit) begin
        ovalid_q <= 1'b1;
      end else if (chr_o.ready) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  // Datapath payload.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      mag_q <= WB'(num_mag);
      rem_q <= '0;
    end
    if (ucode.act == ACT_DIV) begin
      mag_q <= dv_w;
      rem_q <= div_last ? '0 : dv_r;
    end
    if (push) begin
      stk_q[0] <= dv_r;
      for (int k = 1; k < VALUE_BITS; k++) begin
        stk_q[k] <= stk_q[k-1];
      end
    end else if (pop) begin
      for (int k = 0; k < VALUE_BITS - 1; k++) begin
        stk_q[k] <= stk_q[k+1];
      end
    end
    if (emit) begin
      case (ucode.act)
        ACT_SIGN: begin
          ochar_q  <= CHAR_MINUS;
          ofinal_q <= 1'b0;
          obad_q   <= 1'b0;
        end
        ACT_DIGIT: begin
          ochar_q  <= dig_c;
          ofinal_q <= (dcnt_q == DCNT_W'(1));
          obad_q   <= 1'b0;
        end
        ACT_ERR: begin
          ochar_q  <= CHAR_NONE;
          ofinal_q <= 1'b1;
          obad_q   <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  a_stack_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dcnt_q <= DCNT_W'(VALUE_BITS))
    else $error("digit stack overflow");

  a_accept_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (num_i.valid && num_i.ready) |-> (dcnt_q == '0))
    else $error("request accepted with digits pending");

  a_digit_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ucode.act == ACT_DIGIT) |-> (dcnt_q != '0))
    else $error("digit output from empty stack");

  a_err_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && (ucode.act == ACT_ERR)) |=> (ovalid_q && ofinal_q && obad_q))
    else $error("error result not flagged as last");

endmodule

// File: rtl/sirt_seq.sv
// ----------------------------------------------------------------------------
// sirt_seq
// Microcode sequencer: step counter, control ROM and conditional jumps.
// ----------------------------------------------------------------------------
module sirt_seq
  import sirt_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  seq_stat_t stat_i,
  output ucode_t    ucode_o
);

  logic [PC_W-1:0] pc_q, pc_d;
  logic            jump;

  always_comb begin
    ucode_o = ucode_rom(pc_q);
  end

  always_comb begin
    unique case (ucode_o.cond)
      COND_NEXT:     jump = 1'b0;
      COND_ALWAYS:   jump = 1'b1;
      COND_NO_IN:    jump = !stat_i.num_valid;
      COND_LEN_BAD:  jump = stat_i.len_bad;
      COND_CHK_MORE: jump = stat_i.chk_more;
      COND_BAD:      jump = stat_i.bad;
      COND_DIV_MORE: jump = stat_i.div_more;
      COND_MAG_NZ:   jump = stat_i.mag_nz;
      COND_DIG_MORE: jump = stat_i.dig_more;
      default:       jump = 1'b1;
    endcase
    priority if (stat_i.out_stall) begin
      pc_d = pc_q;
    end else if (jump) begin
      pc_d = ucode_o.target;
    end else begin
      pc_d = pc_q + PC_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= PC_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

// File: bench/tb_signed_int_to_radix_text.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_signed_int_to_radix_text
// Self-checking bench for the signed integer to radix text converter. A short
// table of directed requests covers the value extremes, radix 2 and 32 and
// every way the alphabet can be rejected. Random requests then run over random
// alphabets, some broken on purpose. Every character is compared against the
// expected text or a local predictor, under random stalls on both channels and
// one long hold-off of the output channel.
// ----------------------------------------------------------------------------
module tb_signed_int_to_radix_text;
  import sirt_pkg::*;

  typedef enum int {EXP_MODEL, EXP_TEXT, EXP_BAD} exp_e;

  typedef struct {
    string              alpha;
    int unsigned        radix;
    logic signed [31:0] number;
    exp_e               kind;
    string              text;
  } row_t;

  typedef struct {
    logic signed [31:0] number;
    exp_e               kind;
    string              text;
  } req_t;

  typedef struct packed {
    logic [7:0] character;
    logic       final_char;
    logic       alphabet_bad;
  } chr_t;

  localparam logic signed [31:0] NUM_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] NUM_MAX = 32'sh7FFF_FFFF;
  localparam string DEC   = "0123456789";
  localparam string HEX   = "0123456789abcdef";
  localparam string B32   = "0123456789ABCDEFGHIJKLMNOPQRSTUV";
  localparam string DUP32 = "0123456789ABCDEFGHIJKLMNOPQRSTU0";

  logic                 clk_i  = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_wdata_i;

  sirt_num_if #(.VALUE_BITS(32)) num_if ();
  sirt_chr_if chr_if ();

  signed_int_to_radix_text DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .num_i      (num_if),
    .chr_o      (chr_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  alpha_t             alpha_mirror = '0;
  logic [RADIX_W-1:0] radix_mirror = '0;

  req_t        number_q[$];
  chr_t        text_q[$];
  int unsigned queued, accepted;
  int unsigned send_idle_pct, recv_idle_pct;
  int unsigned hold_cycles;
  int unsigned errors, chars_checked, bad_flags, settings;

  function automatic logic [7:0] digit_char(int unsigned k);
    return alpha_mirror[(k >> 3) & 3][(k & 7) * 8 +: 8];
  endfunction

  function automatic bit alphabet_valid();
    int unsigned n;
    logic [7:0]  c;
    n = radix_mirror;
    if (n < 2 || n > MAX_RADIX_DEF) return 1'b0;
    for (int unsigned i = 0; i < n; i++) begin
      c = digit_char(i);
      if (c < CHAR_LOW || c >= CHAR_DEL || c == CHAR_PLUS || c == CHAR_MINUS) return 1'b0;
      for (int unsigned j = i + 1; j < n; j++)
        if (digit_char(j) == c) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void predict_text(logic signed [31:0] value);
    logic [31:0] mag;
    int unsigned radix;
    int unsigned digits[32];
    int          nd;
    if (!alphabet_valid()) begin
      text_q.push_back('{CHAR_NONE, 1'b1, 1'b1});
      return;
    end
    radix = radix_mirror;
    mag   = value;
    if (value[31]) mag = ~mag + 1'b1;
    nd = 0;
    do begin
      digits[nd] = mag % radix;
      mag        = mag / radix;
      nd++;
    end while (mag != 0 && nd < 32);
    if (value[31]) text_q.push_back('{CHAR_MINUS, 1'b0, 1'b0});
    for (int i = nd - 1; i >= 0; i--)
      text_q.push_back('{digit_char(digits[i]), i == 0, 1'b0});
  endfunction

  function automatic alpha_t pack_alpha(string s);
    alpha_t a;
    a = '0;
    for (int i = 0; i < s.len() && i < 32; i++) a[i >> 3][(i & 7) * 8 +: 8] = s[i];
    return a;
  endfunction

  function automatic logic signed [31:0] random_number();
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(5))
          0: return 32'sd0;
          1: return -32'sd1;
          2: return 32'sd1;
          3: return NUM_MIN;
          4: return NUM_MAX;
          default: return NUM_MIN + 32'sd1;
        endcase
      end
      1, 2, 3: return $signed($urandom_range(2000)) - 32'sd1000;
      default: return $urandom;
    endcase
  endfunction

  task automatic write_reg(cfg_idx_e idx, logic [CFG_W-1:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    if (idx == CFG_RADIX) radix_mirror = value[RADIX_W-1:0];
    else alpha_mirror[idx] = value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic load_alphabet(alpha_t a, logic [CFG_W-1:0] radix_word);
    for (int i = 0; i < ALPHA_REGS; i++) write_reg(cfg_idx_e'(i), a[i]);
    write_reg(CFG_RADIX, radix_word);
    settings++;
  endtask

  // all requests taken, all characters back, sequencer settled
  task automatic wait_idle();
    while (accepted != queued || text_q.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic random_alphabet(output alpha_t a, output logic [CFG_W-1:0] radix_word);
    logic [7:0]  pool[$];
    logic [7:0]  tmp, c;
    int unsigned radix, k, p, q;
    for (int i = 0; i < ALPHA_REGS; i++) a[i] = {$urandom, $urandom};
    for (int v = CHAR_LOW; v < CHAR_DEL; v++)
      if (v != CHAR_PLUS && v != CHAR_MINUS) pool.push_back(v[7:0]);
    for (int i = pool.size() - 1; i > 0; i--) begin
      k       = $urandom_range(i);
      tmp     = pool[i];
      pool[i] = pool[k];
      pool[k] = tmp;
    end
    radix = $urandom_range(2, MAX_RADIX_DEF);
    for (int i = 0; i < radix; i++) a[i >> 3][(i & 7) * 8 +: 8] = pool[i];
    if ($urandom_range(99) < 20) begin
      case ($urandom_range(4))
        0: radix = $urandom_range(1);
        1: radix = $urandom_range(63, MAX_RADIX_DEF + 1);
        2: begin
          case ($urandom_range(4))
            0: c = $urandom_range(CHAR_LOW - 1);
            1: c = CHAR_DEL;
            2: c = $urandom_range(255, 128);
            3: c = CHAR_PLUS;
            default: c = CHAR_MINUS;
          endcase
          p = $urandom_range(radix - 1);
          a[p >> 3][(p & 7) * 8 +: 8] = c;
        end
        default: begin
          p = $urandom_range(radix - 1);
          q = (p + 1 + $urandom_range(radix - 2)) % radix;
          a[q >> 3][(q & 7) * 8 +: 8] = a[p >> 3][(p & 7) * 8 +: 8];
        end
      endcase
    end
    radix_word      = {$urandom, $urandom};
    radix_word[5:0] = radix[5:0];
  endtask

  // request side
  initial begin
    req_t cur;
    bit   busy;
    busy          = 1'b0;
    num_if.valid  = 1'b0;
    num_if.number = '0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (num_if.valid && num_if.ready) begin
        case (cur.kind)
          EXP_MODEL: predict_text(cur.number);
          EXP_BAD:   text_q.push_back('{CHAR_NONE, 1'b1, 1'b1});
          default:
            for (int i = 0; i < cur.text.len(); i++)
              text_q.push_back('{cur.text[i], i == cur.text.len() - 1, 1'b0});
        endcase
        accepted++;
        busy = 1'b0;
      end
      @(negedge clk_i);
      if (!busy) begin
        if (number_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cur           = number_q.pop_front();
          busy          = 1'b1;
          num_if.valid  <= 1'b1;
          num_if.number <= cur.number;
        end else begin
          num_if.valid <= 1'b0;
        end
      end
    end
  end

  // result side
  initial begin
    chr_t got, want;
    chr_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (chr_if.valid && chr_if.ready) begin
        got = '{chr_if.character, chr_if.final_char, chr_if.alphabet_bad};
        chars_checked++;
        if (got.alphabet_bad) bad_flags++;
        if (text_q.size() == 0) begin
          errors++;
          if (errors <= 20)
            $display("%0t: unexpected char %h final %b bad %b", $time,
                     got.character, got.final_char, got.alphabet_bad);
        end else begin
          want = text_q.pop_front();
          if (got.character !== want.character || got.final_char !== want.final_char ||
              got.alphabet_bad !== want.alphabet_bad) begin
            errors++;
            if (errors <= 20)
              $display("%0t: expected char %h final %b bad %b, got char %h final %b bad %b",
                       $time, want.character, want.final_char, want.alphabet_bad,
                       got.character, got.final_char, got.alphabet_bad);
          end
        end
      end
      @(negedge clk_i);
      if (hold_cycles != 0) begin
        chr_if.ready <= 1'b0;
        hold_cycles--;
      end else begin
        chr_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    #50_000_000;
    $display("FAIL signed_int_to_radix_text");
    $finish;
  end

  initial begin
    row_t             rows[$];
    string            cur_alpha;
    int unsigned      cur_radix, rand_items, n;
    bit               held;
    alpha_t           a;
    logic [CFG_W-1:0] radix_word;

    cfg_we_i    = 1'b0;
    cfg_idx_i   = CFG_ALPHA_0;
    cfg_wdata_i = '0;
    send_idle_pct = 21;
    recv_idle_pct = 87;

    rows.push_back('{"", 0, 32'sd5, EXP_BAD, ""});
    rows.push_back('{DEC, 10, 32'sd0, EXP_TEXT, "0"});
    rows.push_back('{DEC, 10, NUM_MAX, EXP_TEXT, "2147483647"});
    rows.push_back('{DEC, 10, NUM_MIN, EXP_TEXT, "-2147483648"});
    rows.push_back('{DEC, 10, -32'sd1, EXP_TEXT, "-1"});
    rows.push_back('{DEC, 10, 32'sd1234567, EXP_MODEL, ""});
    rows.push_back('{"01+-", 2, NUM_MIN, EXP_MODEL, ""});
    rows.push_back('{"01+-", 2, NUM_MAX, EXP_MODEL, ""});
    rows.push_back('{"01+-", 2, 32'sd0, EXP_TEXT, "0"});
    rows.push_back('{B32, 32, NUM_MIN, EXP_TEXT, "-2000000"});
    rows.push_back('{B32, 32, NUM_MAX, EXP_TEXT, "1VVVVVV"});
    rows.push_back('{B32, 32, -32'sd1, EXP_TEXT, "-1"});
    rows.push_back('{" ~", 2, 32'sd5, EXP_TEXT, "~ ~"});
    rows.push_back('{"0", 1, 32'sd7, EXP_BAD, ""});
    rows.push_back('{B32, 33, 32'sd7, EXP_BAD, ""});
    rows.push_back('{B32, 63, 32'sd7, EXP_BAD, ""});
    rows.push_back('{"01\037", 3, 32'sd7, EXP_BAD, ""});
    rows.push_back('{"01\177", 3, 32'sd7, EXP_BAD, ""});
    rows.push_back('{"01\200", 3, 32'sd7, EXP_BAD, ""});
    rows.push_back('{"01\377", 3, 32'sd7, EXP_BAD, ""});
    rows.push_back('{"01+", 3, 32'sd7, EXP_BAD, ""});
    rows.push_back('{"01-", 3, 32'sd7, EXP_BAD, ""});
    rows.push_back('{DUP32, 32, 32'sd7, EXP_BAD, ""});
    rows.push_back('{HEX, 16, 32'shDEAD_BEEF, EXP_MODEL, ""});
    rows.push_back('{HEX, 16, 32'sh1234_ABCD, EXP_MODEL, ""});

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    cur_alpha = "";
    cur_radix = 0;
    foreach (rows[i]) begin
      if (rows[i].alpha != cur_alpha || rows[i].radix != cur_radix) begin
        wait_idle();
        load_alphabet(pack_alpha(rows[i].alpha), rows[i].radix);
        cur_alpha = rows[i].alpha;
        cur_radix = rows[i].radix;
      end
      number_q.push_back('{rows[i].number, rows[i].kind, rows[i].text});
      queued++;
    end

    rand_items = 0;
    held       = 1'b0;
    while (rand_items < 345) begin
      wait_idle();
      if (rand_items >= 230) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else if (rand_items >= 115) begin
        send_idle_pct = 87;
        recv_idle_pct = 21;
      end
      random_alphabet(a, radix_word);
      load_alphabet(a, radix_word);
      n = $urandom_range(24, 8);
      repeat (n) begin
        number_q.push_back('{random_number(), EXP_MODEL, ""});
        queued++;
        rand_items++;
      end
      // output stalled long enough for the request side to back up
      if (!held && rand_items >= 230) begin
        hold_cycles = 400;
        held        = 1'b1;
      end
    end

    wait_idle();
    repeat (20) @(negedge clk_i);
    $display("Ran %0d directed and %0d random requests across %0d alphabet settings.",
             rows.size(), rand_items, settings);
    $display("Checked %0d output characters, %0d of them bad-alphabet flags.",
             chars_checked, bad_flags);
    if (errors == 0 && text_q.size() == 0) begin
      $display("PASS signed_int_to_radix_text");
    end else begin
      $display("FAIL signed_int_to_radix_text");
    end
    $finish;
  end

endmodule
